@@ sv/btl_pkg.sv @@
// Shared types, constants and character classifiers of the basic token lexer.
package btl_pkg;

    localparam int MAX_TOKEN_CHARS = 32;
    localparam int IDX_W           = (MAX_TOKEN_CHARS > 1) ? $clog2(MAX_TOKEN_CHARS) : 1;
    localparam int LEN_W           = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int ADDR_W          = IDX_W + 1;
    localparam int BUF_DEPTH       = 2 ** ADDR_W;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_CHARS);

    localparam logic [3:0] KIND_LINE   = 4'd0;
    localparam logic [3:0] KIND_EQUALS = 4'd1;
    localparam logic [3:0] KIND_OPER   = 4'd2;
    localparam logic [3:0] KIND_LPAREN = 4'd3;
    localparam logic [3:0] KIND_RPAREN = 4'd4;
    localparam logic [3:0] KIND_WORD   = 4'd5;
    localparam logic [3:0] KIND_LABEL  = 4'd6;
    localparam logic [3:0] KIND_NUMBER = 4'd7;
    localparam logic [3:0] KIND_STRING = 4'd8;

    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_GT     = 8'h3E;

    typedef enum logic [1:0] {
        MODE_DEFAULT,
        MODE_WORD,
        MODE_NUMBER,
        MODE_STRING
    } mode_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_TOK,
        BK_EMPTY,
        BK_SYM
    } back_state_t;

    // One queued command: an optional buffered token, then an optional symbol.
    typedef struct packed {
        logic             tok;
        logic [3:0]       tok_kind;
        logic [LEN_W-1:0] tok_len;
        logic             tok_trunc;
        logic             tok_bank;
        logic             sym;
        logic [3:0]       sym_kind;
        logic [7:0]       sym_char;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    // Returns {hit, kind} for the single-character symbols.
    function automatic logic [4:0] sym_lookup(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c)
            CHAR_NL: begin
                r = {1'b1, KIND_LINE};
            end
            CHAR_EQ: begin
                r = {1'b1, KIND_EQUALS};
            end
            CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_LT, CHAR_GT: begin
                r = {1'b1, KIND_OPER};
            end
            CHAR_LPAREN: begin
                r = {1'b1, KIND_LPAREN};
            end
            CHAR_RPAREN: begin
                r = {1'b1, KIND_RPAREN};
            end
            default: begin
                r = 5'd0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/btl_front.sv @@
// Front end: takes source bytes, runs the lexer mode machine and fills the text buffer.
module btl_front import btl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       q_push,
    output cmd_t       q_cmd,
    input  logic       q_full,
    output buf_wr_t    buf_wr,
    input  logic       tok_done
);

    logic             hold_v_reg, hold_v_next;
    logic [7:0]       hold_char_reg;
    logic             hold_eot_reg;
    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic             tok_pend_reg, tok_pend_next;

    logic       c_letter, c_digit, c_quote, c_colon;
    logic [4:0] c_sym;
    logic       app, run_default, step;
    buf_wr_t    wr_req;

    assign c_letter = is_letter(hold_char_reg);
    assign c_digit  = is_digit(hold_char_reg);
    assign c_quote  = (hold_char_reg == CHAR_QUOTE);
    assign c_colon  = (hold_char_reg == CHAR_COLON);
    assign c_sym    = sym_lookup(hold_char_reg);

    always_comb begin
        mode_next   = mode_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        bank_next   = bank_reg;
        q_cmd       = '0;
        app         = 1'b0;
        run_default = 1'b0;
        wr_req      = '0;

        case (mode_reg)
            MODE_DEFAULT: begin
                run_default = 1'b1;
            end
            MODE_WORD: begin
                if (c_letter || c_digit) begin
                    app = 1'b1;
                end else begin
                    q_cmd.tok      = 1'b1;
                    q_cmd.tok_kind = c_colon ? KIND_LABEL : KIND_WORD;
                    run_default    = !c_colon;
                end
            end
            MODE_NUMBER: begin
                if (c_digit) begin
                    app = 1'b1;
                end else begin
                    q_cmd.tok      = 1'b1;
                    q_cmd.tok_kind = KIND_NUMBER;
                    run_default    = 1'b1;
                end
            end
            MODE_STRING: begin
                if (c_quote) begin
                    q_cmd.tok      = 1'b1;
                    q_cmd.tok_kind = KIND_STRING;
                end else begin
                    app = 1'b1;
                end
            end
            default: begin
                run_default = 1'b1;
            end
        endcase

        // A finished token hands its bank to the back end; new text goes to the other bank.
        if (q_cmd.tok) begin
            q_cmd.tok_len   = len_reg;
            q_cmd.tok_trunc = ovf_reg;
            q_cmd.tok_bank  = bank_reg;
            len_next        = '0;
            ovf_next        = 1'b0;
            bank_next       = ~bank_reg;
            mode_next       = MODE_DEFAULT;
        end

        if (run_default) begin
            if (c_sym[4]) begin
                q_cmd.sym      = 1'b1;
                q_cmd.sym_kind = c_sym[3:0];
                q_cmd.sym_char = hold_char_reg;
            end else if (c_letter) begin
                app       = 1'b1;
                mode_next = MODE_WORD;
            end else if (c_digit) begin
                app       = 1'b1;
                mode_next = MODE_NUMBER;
            end else if (c_quote) begin
                mode_next = MODE_STRING;
            end
        end

        if (app) begin
            if (len_next < MAX_LEN) begin
                wr_req.en   = 1'b1;
                wr_req.addr = {bank_next, len_next[IDX_W-1:0]};
                wr_req.data = hold_char_reg;
                len_next    = len_next + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (hold_eot_reg) begin
            mode_next = MODE_DEFAULT;
            len_next  = '0;
            ovf_next  = 1'b0;
        end
    end

    // A byte that ends a token waits until the back end has released the other bank.
    assign step     = hold_v_reg && !q_full && !(q_cmd.tok && tok_pend_reg);
    assign q_push   = step && (q_cmd.tok || q_cmd.sym);
    assign s_tready = !hold_v_reg || step;

    // The buffer is written only in the cycle that consumes the held byte.
    always_comb begin
        buf_wr    = wr_req;
        buf_wr.en = wr_req.en && step;
    end

    always_comb begin
        if (s_tvalid && s_tready) begin
            hold_v_next = 1'b1;
        end else if (step) begin
            hold_v_next = 1'b0;
        end else begin
            hold_v_next = hold_v_reg;
        end

        if (q_push && q_cmd.tok) begin
            tok_pend_next = 1'b1;
        end else if (tok_done) begin
            tok_pend_next = 1'b0;
        end else begin
            tok_pend_next = tok_pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg   <= 1'b0;
            mode_reg     <= MODE_DEFAULT;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            bank_reg     <= 1'b0;
            tok_pend_reg <= 1'b0;
        end else begin
            hold_v_reg   <= hold_v_next;
            tok_pend_reg <= tok_pend_next;
            if (step) begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                ovf_reg  <= ovf_next;
                bank_reg <= bank_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hold_char_reg <= s_tdata;
            hold_eot_reg  <= s_tlast;
        end
    end

endmodule

@@ sv/btl_queue.sv @@
// Short command queue between the lexer front end and the result back end.
module btl_queue import btl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && valid)) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (!push && pop && valid) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop && valid) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/btl_back.sv @@
// Back end: holds the two-bank text buffer and sends each command out as result beats.
module btl_back import btl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  cmd_t       q_head,
    output logic       q_pop,
    input  buf_wr_t    buf_wr,
    output logic       tok_done,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [6:0] m_tuser
);

    back_state_t      state_reg, state_next;
    cmd_t             cur_reg, cur_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [BUF_DEPTH];

    logic       last_char, m_fire;
    logic [3:0] o_kind;
    logic       o_empty, o_run_end, o_trunc;

    assign last_char = ((LEN_W'(idx_reg) + LEN_W'(1)) == cur_reg.tok_len);
    assign m_fire    = m_tvalid && m_tready;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        tok_done   = 1'b0;
        m_tvalid   = 1'b0;
        m_tdata    = '0;
        m_tlast    = 1'b0;
        o_kind     = cur_reg.tok_kind;
        o_empty    = 1'b0;
        o_run_end  = 1'b0;
        o_trunc    = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    idx_next = '0;
                    if (!q_head.tok) begin
                        state_next = BK_SYM;
                    end else if (q_head.tok_len == '0) begin
                        state_next = BK_EMPTY;
                    end else begin
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ: begin
                state_next = BK_TOK;
            end
            BK_TOK: begin
                m_tvalid  = 1'b1;
                m_tdata   = rd_data_reg;
                m_tlast   = last_char;
                o_run_end = last_char && !cur_reg.sym;
                o_trunc   = cur_reg.tok_trunc;
                if (m_fire) begin
                    if (last_char) begin
                        tok_done   = 1'b1;
                        state_next = cur_reg.sym ? BK_SYM : BK_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            BK_EMPTY: begin
                m_tvalid  = 1'b1;
                m_tlast   = 1'b1;
                o_empty   = 1'b1;
                o_run_end = !cur_reg.sym;
                o_trunc   = cur_reg.tok_trunc;
                if (m_fire) begin
                    tok_done   = 1'b1;
                    state_next = cur_reg.sym ? BK_SYM : BK_IDLE;
                end
            end
            BK_SYM: begin
                m_tvalid  = 1'b1;
                m_tdata   = cur_reg.sym_char;
                m_tlast   = 1'b1;
                o_kind    = cur_reg.sym_kind;
                o_run_end = 1'b1;
                if (m_fire) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        m_tuser = {o_trunc, o_run_end, o_empty, o_kind};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
    end

    // The front end writes one bank while this side reads the other.
    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            mem[buf_wr.addr] <= buf_wr.data;
        end
        if (state_next == BK_TOK) begin
            rd_data_reg <= mem[{cur_reg.tok_bank, idx_next}];
        end
    end

endmodule

@@ sv/basic_token_lexer_top.sv @@
// Top level of the basic token lexer: front end, command queue and back end.
//
//  Channel | Direction | tdata          | tlast       | tuser (lowest bit up)
//  s_*     | in        | text_char[7:0] | end_of_text | -
//  m_*     | out       | token_char     | token_end   | token_kind[3:0], token_empty,
//          |           |                |             | run_end, token_truncated
//
// The front end handles each byte in turn; bytes that give no result never reach the queue.
// The back end takes a command, reads the buffer in BK_READ for a non-empty token, then sends
// one beat per token character and one for a symbol; an empty string gives a single empty beat.
// A byte that ends a token waits in the front end while the previous token is still being sent.
// Reset is synchronous and active low; the text buffer needs no clearing pass.
// Either side may stall at any time; the queue holds two commands.
module basic_token_lexer_top import btl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] token_char
    output logic       m_tlast,
    output logic [6:0] m_tuser    // [3:0] token_kind, [4] token_empty, [5] run_end,
                                  // [6] token_truncated
);

    logic    q_push, q_full, q_pop, q_valid, tok_done;
    cmd_t    q_cmd, q_head;
    buf_wr_t buf_wr;

    btl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .q_full   (q_full),
        .buf_wr   (buf_wr),
        .tok_done (tok_done)
    );

    btl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    btl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .buf_wr   (buf_wr),
        .tok_done (tok_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ sv/btl_checker.sv @@
// Port-level checks on the basic token lexer result stream, bound to the top level.
module btl_checker import btl_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [6:0] m_tuser
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_run_end_ends_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[5] |-> m_tlast)
        else $error("run ended inside a token");

    a_empty_string: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4] |-> m_tlast && (m_tdata == 8'd0)
            && (m_tuser[3:0] == KIND_STRING))
        else $error("empty token that is not a lone string beat");

    a_symbol_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:0] < KIND_WORD) |-> m_tlast && m_tuser[5] && !m_tuser[6])
        else $error("symbol beat not a complete single-beat run");

endmodule

bind basic_token_lexer_top btl_checker u_btl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ tb/basic_token_lexer_top_tb.sv @@
// Self-checking testbench for the basic token lexer: table-driven and random text.
module basic_token_lexer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btl_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RAND_PER_PHASE = 18;
    localparam int NUM_ROWS       = 26;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // One beat of token output, split into its fields.
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       empty;
        logic       tend;
        logic       rend;
        logic       trunc;
    } tok_beat_t;

    // A directed byte; where typed is set, the listed beat (or none) is expected as is.
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic       has_beat;
        tok_beat_t  beat;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] text_char
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] token_char
    logic       m_tlast;
    logic [6:0] m_tuser;   // [3:0] token_kind, [4] token_empty, [5] run_end,
                           // [6] token_truncated

    int s_idle_pct;
    int m_idle_pct;
    int fail_count  = 0;
    int cycle_count = 0;
    int useful_items;

    // Lexer state as the testbench tracks it.
    mode_t      lx_mode;
    logic [7:0] lx_text [MAX_TOKEN_CHARS];
    int         lx_len;
    logic       lx_cut;
    tok_beat_t  step_beats[$];
    tok_beat_t  beats_due[$];

    dir_row_t dir_rows [NUM_ROWS] = '{
        '{CHAR_NL,     1'b0, 1'b1, 1'b1, '{KIND_LINE,   CHAR_NL,     1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_EQ,     1'b0, 1'b1, 1'b1, '{KIND_EQUALS, CHAR_EQ,     1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_PLUS,   1'b0, 1'b1, 1'b1, '{KIND_OPER,   CHAR_PLUS,   1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_MINUS,  1'b0, 1'b1, 1'b1, '{KIND_OPER,   CHAR_MINUS,  1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_STAR,   1'b0, 1'b1, 1'b1, '{KIND_OPER,   CHAR_STAR,   1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_SLASH,  1'b0, 1'b1, 1'b1, '{KIND_OPER,   CHAR_SLASH,  1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_LT,     1'b0, 1'b1, 1'b1, '{KIND_OPER,   CHAR_LT,     1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_GT,     1'b0, 1'b1, 1'b1, '{KIND_OPER,   CHAR_GT,     1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_LPAREN, 1'b0, 1'b1, 1'b1, '{KIND_LPAREN, CHAR_LPAREN, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{CHAR_RPAREN, 1'b0, 1'b1, 1'b1, '{KIND_RPAREN, CHAR_RPAREN, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{8'hFF,       1'b0, 1'b1, 1'b0, '0},
        '{8'h00,       1'b0, 1'b1, 1'b0, '0},
        '{"A",         1'b0, 1'b0, 1'b0, '0},
        '{"z",         1'b0, 1'b0, 1'b0, '0},
        '{"9",         1'b0, 1'b0, 1'b0, '0},
        '{CHAR_COLON,  1'b0, 1'b0, 1'b0, '0},
        '{"0",         1'b0, 1'b0, 1'b0, '0},
        '{"a",         1'b0, 1'b0, 1'b0, '0},
        '{CHAR_QUOTE,  1'b0, 1'b0, 1'b0, '0},
        '{CHAR_QUOTE,  1'b0, 1'b0, 1'b0, '0},
        '{CHAR_QUOTE,  1'b0, 1'b0, 1'b0, '0},
        '{8'h80,       1'b0, 1'b0, 1'b0, '0},
        '{CHAR_QUOTE,  1'b0, 1'b0, 1'b0, '0},
        '{"7",         1'b1, 1'b1, 1'b0, '0},
        '{"x",         1'b0, 1'b0, 1'b0, '0},
        '{CHAR_STAR,   1'b1, 1'b0, 1'b0, '0}
    };

    basic_token_lexer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Appends one beat at the tail of a beat list.
    function automatic void queue_beat(ref tok_beat_t q[$], input tok_beat_t b);
        q.insert(q.size(), b);
    endfunction

    function void keep_char(input logic [7:0] c);
        if (lx_len < MAX_TOKEN_CHARS) begin
            lx_text[lx_len] = c;
            lx_len++;
        end else begin
            lx_cut = 1'b1;
        end
    endfunction

    // Sends the buffered text as one token; an empty buffer gives one empty beat.
    function void emit_token(input logic [3:0] kind);
        int i;
        if (lx_len == 0) begin
            queue_beat(step_beats, '{kind, 8'h00, 1'b1, 1'b1, 1'b0, lx_cut});
        end else begin
            for (i = 0; i < lx_len; i++)
                queue_beat(step_beats,
                           '{kind, lx_text[i], 1'b0, i == lx_len - 1, 1'b0, lx_cut});
        end
        lx_len  = 0;
        lx_cut  = 1'b0;
        lx_mode = MODE_DEFAULT;
    endfunction

    // Works out the beats that one text byte causes and advances the lexer state.
    function void lex_byte(input logic [7:0] c, input logic eot);
        logic       again;
        logic       hit;
        logic [3:0] kind;
        int         pass;
        step_beats.delete();
        again = 1'b1;
        for (pass = 0; pass < 2 && again; pass++) begin
            again = 1'b0;
            case (lx_mode)
                MODE_DEFAULT: begin
                    hit  = 1'b1;
                    kind = KIND_LINE;
                    case (c)
                        CHAR_NL: begin
                            kind = KIND_LINE;
                        end
                        CHAR_EQ: begin
                            kind = KIND_EQUALS;
                        end
                        CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_LT, CHAR_GT: begin
                            kind = KIND_OPER;
                        end
                        CHAR_LPAREN: begin
                            kind = KIND_LPAREN;
                        end
                        CHAR_RPAREN: begin
                            kind = KIND_RPAREN;
                        end
                        default: begin
                            hit = 1'b0;
                        end
                    endcase
                    if (hit) begin
                        queue_beat(step_beats, '{kind, c, 1'b0, 1'b1, 1'b0, 1'b0});
                    end else if (is_alpha(c)) begin
                        keep_char(c);
                        lx_mode = MODE_WORD;
                    end else if (is_num(c)) begin
                        keep_char(c);
                        lx_mode = MODE_NUMBER;
                    end else if (c == CHAR_QUOTE) begin
                        lx_mode = MODE_STRING;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(c) || is_num(c)) begin
                        keep_char(c);
                    end else if (c == CHAR_COLON) begin
                        emit_token(KIND_LABEL);
                    end else begin
                        emit_token(KIND_WORD);
                        again = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_num(c)) begin
                        keep_char(c);
                    end else begin
                        emit_token(KIND_NUMBER);
                        again = 1'b1;
                    end
                end
                default: begin
                    if (c == CHAR_QUOTE)
                        emit_token(KIND_STRING);
                    else
                        keep_char(c);
                end
            endcase
        end
        // End of text drops whatever token is still being collected.
        if (eot) begin
            lx_mode = MODE_DEFAULT;
            lx_len  = 0;
            lx_cut  = 1'b0;
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].rend = 1'b1;
    endfunction

    task automatic send_text_byte(input logic [7:0] c, input logic eot, input logic typed,
                                  input logic has_beat, input tok_beat_t beat);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        lex_byte(c, eot);
        if (typed) begin
            if (has_beat)
                queue_beat(beats_due, beat);
        end else begin
            foreach (step_beats[i])
                queue_beat(beats_due, step_beats[i]);
        end
        useful_items++;
    endtask

    task automatic feed(input logic [7:0] c, input logic eot);
        send_text_byte(c, eot, 1'b0, 1'b0, '0);
    endtask

    task automatic wait_all_beats();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_due.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [7:0] any_symbol();
        case ($urandom_range(9))
            0: return CHAR_NL;
            1: return CHAR_EQ;
            2: return CHAR_PLUS;
            3: return CHAR_MINUS;
            4: return CHAR_STAR;
            5: return CHAR_SLASH;
            6: return CHAR_LT;
            7: return CHAR_GT;
            8: return CHAR_LPAREN;
            default: return CHAR_RPAREN;
        endcase
    endfunction

    function automatic logic [7:0] any_letter();
        return $urandom_range(1) ? 8'(8'h41 + $urandom_range(25)) : 8'(8'h61 + $urandom_range(25));
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'(8'h30 + $urandom_range(9));
    endfunction

    // Mostly short tokens, now and then one near or past the buffer size.
    function automatic int token_len(input int min_len);
        return ($urandom_range(11) == 0) ? $urandom_range(28, 40) : $urandom_range(min_len, 6);
    endfunction

    // One well-formed run (symbol, word, number or string) or a noise byte.
    // A negative length asks for a random one.
    task automatic gen_run(input int sel, input int n);
        logic [7:0] c;
        int         len;
        int         i;
        if (sel < 12) begin
            feed(any_symbol(), 1'b0);
        end else if (sel < 35) begin
            len = (n < 0) ? token_len(1) : n;
            feed(any_letter(), 1'b0);
            for (i = 1; i < len; i++)
                feed(($urandom_range(2) == 0) ? any_digit() : any_letter(), 1'b0);
            case ($urandom_range(4))
                0: c = CHAR_COLON;
                1: c = CHAR_SPACE;
                2: c = any_symbol();
                3: c = CHAR_QUOTE;
                default: c = 8'($urandom_range(255));
            endcase
            feed(c, $urandom_range(15) == 0);
        end else if (sel < 55) begin
            len = (n < 0) ? token_len(1) : n;
            for (i = 0; i < len; i++)
                feed(any_digit(), 1'b0);
            case ($urandom_range(3))
                0: c = CHAR_SPACE;
                1: c = any_symbol();
                2: c = any_letter();
                default: c = 8'($urandom_range(255));
            endcase
            feed(c, $urandom_range(15) == 0);
        end else if (sel < 75) begin
            len = (n < 0) ? token_len(0) : n;
            feed(CHAR_QUOTE, 1'b0);
            for (i = 0; i < len; i++) begin
                c = 8'($urandom_range(255));
                while (c == CHAR_QUOTE)
                    c = 8'($urandom_range(255));
                feed(c, 1'b0);
            end
            // A string left open now and then.
            if ($urandom_range(9) != 0)
                feed(CHAR_QUOTE, $urandom_range(15) == 0);
        end else if (sel < 88) begin
            feed(8'($urandom_range(255)), 1'b0);
        end else begin
            feed(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Output side: checks each accepted beat and throttles m_tready.
    always @(posedge aclk) begin
        tok_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (beats_due.size() == 0) begin
                $error("token beat with none expected: kind %0d char %02h",
                       m_tuser[3:0], m_tdata);
                fail_count++;
            end else begin
                want = beats_due.pop_front();
                check_field("token_kind", want.kind, m_tuser[3:0]);
                check_field("token_char", want.ch, m_tdata);
                check_field("token_empty", want.empty, m_tuser[4]);
                check_field("token_end", want.tend, m_tlast);
                check_field("run_end", want.rend, m_tuser[5]);
                check_field("token_truncated", want.trunc, m_tuser[6]);
            end
        end
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("basic_token_lexer_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        s_idle_pct = 7;
        m_idle_pct = 82;
        lx_mode    = MODE_DEFAULT;
        lx_len     = 0;
        lx_cut     = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_text_byte(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed,
                           dir_rows[i].has_beat, dir_rows[i].beat);
        // Hold the input until the directed tokens are all out.
        wait_all_beats();

        for (int phase = 0; phase < 3; phase++) begin
            s_idle_pct   = (phase == 0) ? 7 : (phase == 1) ? 82 : 0;
            m_idle_pct   = (phase == 0) ? 82 : (phase == 1) ? 7 : 0;
            useful_items = 0;
            if (phase == 0) begin
                // Make sure a long word, a long number and a long string each hit the buffer limit at least once.
                gen_run(20, 36);
                gen_run(40, 33);
                gen_run(60, 34);
            end
            while (useful_items < RAND_PER_PHASE)
                gen_run($urandom_range(99), -1);
            wait_all_beats();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (beats_due.size() != 0) begin
            $error("%0d expected token beats never arrived", beats_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("basic_token_lexer_top_tb: PASS");
        else
            $display("basic_token_lexer_top_tb: FAIL");
        $finish;
    end

endmodule
